/* rtl/lrbp_pkg.sv */
package lrbp_pkg;

    localparam int TIME_W = 32;
    localparam int FAIL_W = 5;
    localparam int STEP_W = 3;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [FAIL_W-1:0] t_fail;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_fail MAX_FAILURES = t_fail'(16);

    // Link commands.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // Wifi states.
    localparam logic [2:0] WS_UNCONF       = 3'd0;
    localparam logic [2:0] WS_STORAGE      = 3'd1;
    localparam logic [2:0] WS_CONN_UNAVAIL = 3'd2;
    localparam logic [2:0] WS_CONNECTING   = 3'd5;
    localparam logic [2:0] WS_CONNECTED    = 3'd6;
    localparam logic [2:0] WS_BACKOFF      = 3'd7;

    // Lan states.
    localparam logic [2:0] LS_UNCONF       = 3'd0;
    localparam logic [2:0] LS_STORAGE      = 3'd1;
    localparam logic [2:0] LS_CONN_UNAVAIL = 3'd2;
    localparam logic [2:0] LS_WIFI_PEND    = 3'd3;
    localparam logic [2:0] LS_ENROLL       = 3'd4;
    localparam logic [2:0] LS_TIME         = 3'd5;
    localparam logic [2:0] LS_TLS          = 3'd6;
    localparam logic [2:0] LS_BLE          = 3'd7;

    // Link observations.
    localparam logic [2:0] OBS_DOWN       = 3'd0;
    localparam logic [2:0] OBS_CONNECTING = 3'd1;
    localparam logic [2:0] OBS_ACCEPTED   = 3'd2;
    localparam logic [2:0] OBS_DOWNGRADED = 3'd3;
    localparam logic [2:0] OBS_FAILED     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_INITIAL = 2'd0;
    localparam logic [1:0] REG_MAX     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    // Micro-operations executed by the datapath.
    typedef logic [2:0] t_op;
    localparam t_op OP_CLR     = 3'd0;
    localparam t_op OP_POLICY  = 3'd1;
    localparam t_op OP_BO_INC  = 3'd2;
    localparam t_op OP_BO_LOOP = 3'd3;
    localparam t_op OP_BO_SET  = 3'd4;
    localparam t_op OP_EMIT    = 3'd5;

    // Program addresses.
    localparam t_step S_CLR     = 3'd0;
    localparam t_step S_POLICY  = 3'd1;
    localparam t_step S_BO_INC  = 3'd2;
    localparam t_step S_BO_LOOP = 3'd3;
    localparam t_step S_BO_SET  = 3'd4;
    localparam t_step S_EMIT    = 3'd5;

    typedef struct packed {
        t_op   op;
        t_step next;   // taken when the condition is false
        t_step alt;    // taken when the condition is true
    } t_uword;

    typedef struct packed {
        logic busy;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic cond;
        logic stall;
    } t_stat;

    typedef struct packed {
        t_time initial_ms;
        t_time max_ms;
        t_time timeout_ms;
    } t_cfg;

    // Control store: one word per step.
    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        unique case (step)
            S_CLR:     w = '{op: OP_CLR,     next: S_POLICY,  alt: S_POLICY};
            S_POLICY:  w = '{op: OP_POLICY,  next: S_EMIT,    alt: S_BO_INC};
            S_BO_INC:  w = '{op: OP_BO_INC,  next: S_BO_LOOP, alt: S_BO_LOOP};
            S_BO_LOOP: w = '{op: OP_BO_LOOP, next: S_BO_LOOP, alt: S_BO_SET};
            S_BO_SET:  w = '{op: OP_BO_SET,  next: S_EMIT,    alt: S_EMIT};
            S_EMIT:    w = '{op: OP_EMIT,    next: S_CLR,     alt: S_CLR};
            default:   w = '{op: OP_EMIT,    next: S_CLR,     alt: S_CLR};
        endcase
        return w;
    endfunction

endpackage

/* rtl/lrbp_if.sv */
interface lrbp_item_if import lrbp_pkg::*; ();
    logic       valid;
    logic       ready;
    t_time      now_ms;
    logic       restart;
    logic       store_ready;
    logic       wifi_configured;
    logic       remote_allowed;
    logic       gateway_configured;
    logic       gateway_enrolled;
    logic       time_valid;
    logic       ble_session;
    logic [2:0] link_observation;

    modport source (
        output valid, now_ms, restart, store_ready, wifi_configured, remote_allowed,
               gateway_configured, gateway_enrolled, time_valid, ble_session,
               link_observation,
        input  ready
    );
    modport sink (
        input  valid, now_ms, restart, store_ready, wifi_configured, remote_allowed,
               gateway_configured, gateway_enrolled, time_valid, ble_session,
               link_observation,
        output ready
    );
endinterface

interface lrbp_result_if import lrbp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] wifi_state;
    logic [2:0] lan_state;
    t_fail      failure_count;
    t_time      retry_remaining_ms;

    modport source (
        output valid, action, wifi_state, lan_state, failure_count, retry_remaining_ms,
        input  ready
    );
    modport sink (
        input  valid, action, wifi_state, lan_state, failure_count, retry_remaining_ms,
        output ready
    );
endinterface

interface lrbp_cfg_if import lrbp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] index;
    t_time      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lrbp_useq.sv */
module lrbp_useq import lrbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic   r_busy, n_busy;
    t_step  r_step, n_step;
    t_uword w_word;

    assign w_word = uc_rom(r_step);
    assign o_ctrl = '{busy: r_busy, op: w_word.op};

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = S_CLR;
            end
        end else if (w_word.op == OP_EMIT) begin
            // The last step waits until the result register can take the beat.
            if (!i_stat.stall) begin
                n_busy = 1'b0;
                n_step = S_CLR;
            end
        end else begin
            n_step = i_stat.cond ? w_word.alt : w_word.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= S_CLR;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    a_start_at_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && i_start) |=> (r_busy && r_step == S_CLR))
        else $error("sequencer did not enter its first step");

    a_clr_to_policy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == S_CLR) |=> (r_busy && r_step == S_POLICY))
        else $error("clear step not followed by policy step");

    a_emit_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == S_EMIT && i_stat.stall) |=> (r_busy && r_step == S_EMIT))
        else $error("result step left while output stalled");

endmodule

/* rtl/lrbp_dpath.sv */
module lrbp_dpath import lrbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_cfg  i_cfg,
    output t_stat o_stat,
    lrbp_item_if.sink     i_item,
    lrbp_result_if.source o_result
);

    // Latched tick.
    t_time      r_now;
    logic       r_restart, r_store, r_wcfg, r_remote, r_gcfg, r_enrolled, r_tvalid, r_ble;
    logic [2:0] r_obs;

    // Policy state.
    logic [2:0] r_wifi, n_wifi;
    logic [2:0] r_lan, n_lan;
    t_fail      r_fail, n_fail;
    t_time      r_deadline, n_deadline;
    t_time      r_cstart, n_cstart;
    logic [1:0] r_action, n_action;

    // Backoff working registers.
    t_time      r_delay, n_delay;
    t_fail      r_cnt, n_cnt;

    // Result register.
    logic       r_o_valid, n_o_valid;
    logic [1:0] r_o_action;
    logic [2:0] r_o_wifi, r_o_lan;
    t_fail      r_o_fail;
    t_time      r_o_remaining;
    logic       w_load;

    logic       w_accept;
    logic       w_prereq_ok;
    logic [2:0] w_code, w_lan_base;
    t_time      w_elapsed, w_since_dl, w_delay_clamped;
    logic       w_timed_out, w_dl_pending, w_loop_done, w_at_half;
    logic       w_cond, w_stall;

    assign i_item.ready = !i_ctrl.busy;
    assign w_accept     = i_item.valid && !i_ctrl.busy;

    // Decode of the latched flags.
    assign w_prereq_ok = r_store && r_wcfg && r_remote;
    assign w_code      = !r_store ? WS_STORAGE : (!r_wcfg ? WS_UNCONF : WS_CONN_UNAVAIL);
    assign w_lan_base  = !r_gcfg ? LS_UNCONF : (r_ble ? LS_BLE : LS_WIFI_PEND);

    // Wrap-safe time arithmetic.
    assign w_elapsed    = r_now - r_cstart;
    assign w_timed_out  = w_elapsed >= i_cfg.timeout_ms;
    assign w_since_dl   = r_now - r_deadline;
    assign w_dl_pending = (r_deadline != '0) && w_since_dl[TIME_W-1];

    assign w_at_half       = r_delay >= (i_cfg.max_ms >> 1);
    assign w_loop_done     = (r_cnt >= r_fail) || w_at_half;
    assign w_delay_clamped = (r_delay > i_cfg.max_ms) ? i_cfg.max_ms : r_delay;

    assign w_stall = r_o_valid && !o_result.ready;
    assign o_stat  = '{cond: w_cond, stall: w_stall};
    assign w_load  = i_ctrl.busy && (i_ctrl.op == OP_EMIT) && !w_stall;

    always_comb begin
        n_wifi     = r_wifi;
        n_lan      = r_lan;
        n_fail     = r_fail;
        n_deadline = r_deadline;
        n_cstart   = r_cstart;
        n_action   = r_action;
        n_delay    = r_delay;
        n_cnt      = r_cnt;
        w_cond     = 1'b0;
        if (i_ctrl.busy) begin
            unique case (i_ctrl.op)
                OP_CLR: begin
                    if (r_restart) begin
                        n_wifi     = WS_UNCONF;
                        n_lan      = LS_UNCONF;
                        n_fail     = '0;
                        n_deadline = '0;
                        n_cstart   = '0;
                    end
                end
                OP_POLICY: begin
                    if (!w_prereq_ok) begin
                        n_wifi     = w_code;
                        n_lan      = w_code;
                        n_fail     = '0;
                        n_deadline = '0;
                        n_action   = (r_obs == OBS_DOWN) ? ACT_NONE : ACT_STOP;
                    end else begin
                        n_lan = w_lan_base;
                        case (r_obs) inside
                            OBS_DOWNGRADED, OBS_FAILED: begin
                                n_action = ACT_STOP;
                                w_cond   = 1'b1;
                            end
                            OBS_ACCEPTED: begin
                                n_wifi = WS_CONNECTED;
                                if (!r_gcfg) begin
                                    n_lan = LS_UNCONF;
                                end else if (r_ble) begin
                                    n_lan = LS_BLE;
                                end else if (!r_enrolled) begin
                                    n_lan = LS_ENROLL;
                                end else if (!r_tvalid) begin
                                    n_lan = LS_TIME;
                                end else begin
                                    n_lan = LS_TLS;
                                end
                                n_fail     = '0;
                                n_deadline = '0;
                                n_action   = ACT_NONE;
                            end
                            OBS_CONNECTING: begin
                                if (w_timed_out) begin
                                    n_action = ACT_STOP;
                                    w_cond   = 1'b1;
                                end else begin
                                    n_wifi   = WS_CONNECTING;
                                    n_action = ACT_NONE;
                                end
                            end
                            default: begin
                                if (w_dl_pending) begin
                                    n_wifi   = WS_BACKOFF;
                                    n_action = ACT_NONE;
                                end else begin
                                    n_deadline = '0;
                                    n_cstart   = r_now;
                                    n_wifi     = WS_CONNECTING;
                                    n_action   = ACT_START;
                                end
                            end
                        endcase
                    end
                end
                OP_BO_INC: begin
                    if (r_fail < MAX_FAILURES) begin
                        n_fail = r_fail + t_fail'(1);
                    end
                    n_delay = i_cfg.initial_ms;
                    n_cnt   = t_fail'(1);
                end
                OP_BO_LOOP: begin
                    w_cond = w_loop_done;
                    if (r_cnt < r_fail) begin
                        if (w_at_half) begin
                            n_delay = i_cfg.max_ms;
                        end else begin
                            n_delay = {r_delay[TIME_W-2:0], 1'b0};
                            n_cnt   = r_cnt + t_fail'(1);
                        end
                    end
                end
                OP_BO_SET: begin
                    n_deadline = r_now + w_delay_clamped;
                    n_wifi     = WS_BACKOFF;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (w_load) begin
            n_o_valid = 1'b1;
        end else if (o_result.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wifi     <= WS_UNCONF;
            r_lan      <= LS_UNCONF;
            r_fail     <= '0;
            r_deadline <= '0;
            r_cstart   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_wifi     <= n_wifi;
            r_lan      <= n_lan;
            r_fail     <= n_fail;
            r_deadline <= n_deadline;
            r_cstart   <= n_cstart;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_delay  <= n_delay;
        r_cnt    <= n_cnt;
        if (w_accept) begin
            r_now      <= i_item.now_ms;
            r_restart  <= i_item.restart;
            r_store    <= i_item.store_ready;
            r_wcfg     <= i_item.wifi_configured;
            r_remote   <= i_item.remote_allowed;
            r_gcfg     <= i_item.gateway_configured;
            r_enrolled <= i_item.gateway_enrolled;
            r_tvalid   <= i_item.time_valid;
            r_ble      <= i_item.ble_session;
            // Codes above failed are treated as a down link.
            r_obs      <= (i_item.link_observation > OBS_FAILED) ? OBS_DOWN
                                                                 : i_item.link_observation;
        end
        if (w_load) begin
            r_o_action    <= r_action;
            r_o_wifi      <= r_wifi;
            r_o_lan       <= r_lan;
            r_o_fail      <= r_fail;
            r_o_remaining <= ((r_wifi == WS_BACKOFF) && w_dl_pending) ? (r_deadline - r_now)
                                                                      : '0;
        end
    end

    assign o_result.valid              = r_o_valid;
    assign o_result.action             = r_o_action;
    assign o_result.wifi_state         = r_o_wifi;
    assign o_result.lan_state          = r_o_lan;
    assign o_result.failure_count      = r_o_fail;
    assign o_result.retry_remaining_ms = r_o_remaining;

    a_set_enters_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.busy && i_ctrl.op == OP_BO_SET) |=> (r_wifi == WS_BACKOFF))
        else $error("deadline set without entering backoff");

    a_fail_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail <= MAX_FAILURES)
        else $error("failure count above its limit");

    a_remaining_in_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_remaining != '0) |-> (r_o_wifi == WS_BACKOFF))
        else $error("retry time reported outside backoff");

    a_delay_doubles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.busy && i_ctrl.op == OP_BO_LOOP && !w_loop_done)
        |=> (r_delay == {$past(r_delay[TIME_W-2:0]), 1'b0}))
        else $error("backoff delay did not double");

endmodule

/* rtl/link_reconnect_backoff_policy.sv */
// A tick's input beat is latched when accepted; the sequencer then runs the clear and
// policy steps and loads the result register in the emit step. A tick that enters
// backoff (new failure count 1 to 16) also runs the increment, loop and deadline steps.
// One tick at a time: the next input beat is taken only once the result is loaded and
// the sequencer is idle, and the emit step waits while the previous result is unread.
// Reset (synchronous, active low) clears the policy state and restores the registers.
module link_reconnect_backoff_policy import lrbp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lrbp_item_if.sink     i_item,
    lrbp_result_if.source o_result,
    lrbp_cfg_if.sink      i_cfg
);

    // Configuration registers. Writes are only expected while the block is idle,
    // so the channel is always ready. An index past the last register is dropped.
    t_cfg  r_cfg;
    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_start;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_ms <= t_time'(1000);
            r_cfg.max_ms     <= t_time'(60000);
            r_cfg.timeout_ms <= t_time'(15000);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_INITIAL: r_cfg.initial_ms <= i_cfg.data;
                REG_MAX:     r_cfg.max_ms     <= i_cfg.data;
                REG_TIMEOUT: r_cfg.timeout_ms <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // A new tick starts the microprogram on the beat that the datapath latches.
    assign w_start = i_item.valid && i_item.ready;

    // The sequencer walks the control store: clear on restart, evaluate the
    // policy, optionally run the backoff steps (increment, doubling loop, deadline),
    // and finally load the result register. The doubling loop stops early once the
    // delay reaches half the maximum, setting it to the maximum, so backoff ticks end sooner.
    lrbp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // The datapath holds the latched tick, the policy state, the delay register
    // with its step counter, and the output register that parts the result
    // channel from the work in progress.
    lrbp_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cfg    (r_cfg),
        .o_stat   (w_stat),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
